// File: rtl/tps4d_pkg.sv
`timescale 1ns / 1ps

package tps4d_pkg;

  localparam int NUM_AXES       = 4;
  localparam int AXIS_BITS      = 2;
  localparam int VALUE_BITS     = 32;
  localparam int DIM_REG_BITS   = 13;
  localparam int CFG_INDEX_BITS = 4;
  localparam int CFG_DATA_BITS  = 13;

  typedef enum logic [CFG_INDEX_BITS-1:0] {
    CFG_DIM_0  = 4'd0,
    CFG_DIM_1  = 4'd1,
    CFG_DIM_2  = 4'd2,
    CFG_DIM_3  = 4'd3,
    CFG_PERM_0 = 4'd4,
    CFG_PERM_1 = 4'd5,
    CFG_PERM_2 = 4'd6,
    CFG_PERM_3 = 4'd7
  } cfg_idx_e;

endpackage

// File: rtl/tensor_permute_scatter_4d.sv
// Pipeline: each accepted input passes stage registers 1, 2 and 3, then the output register.
// Throughput: one element per cycle; the four pipeline stages share one stall signal
// driven by the output register, so in_ready_o follows out_ready_i while a result waits.
// Reset (rst_ni low, asynchronous): dims 1, identity permutation, position counters
// and all pipeline valid bits cleared.
`timescale 1ns / 1ps

module tensor_permute_scatter_4d #(
  parameter int DIM_BITS  = 12,
  parameter int ADDR_BITS = 24
) (
  input  logic                                     clk_i,
  input  logic                                     rst_ni,
  input  logic                                     cfg_we_i,
  input  logic [tps4d_pkg::CFG_INDEX_BITS-1:0]     cfg_index_i,
  input  logic [tps4d_pkg::CFG_DATA_BITS-1:0]      cfg_data_i,
  input  logic                                     in_valid_i,
  output logic                                     in_ready_o,
  input  logic [tps4d_pkg::VALUE_BITS-1:0]         element_value_i,
  output logic                                     out_valid_o,
  input  logic                                     out_ready_i,
  output logic [ADDR_BITS-1:0]                     dest_index_o,
  output logic [tps4d_pkg::VALUE_BITS-1:0]         moved_value_o,
  output logic                                     last_element_o
);

  localparam int SW   = DIM_BITS + 1;
  localparam int WIDE = ADDR_BITS + 2 * SW;
  localparam int MAXD = 1 << DIM_BITS;
  localparam int NAX  = tps4d_pkg::NUM_AXES;
  localparam int AXB  = tps4d_pkg::AXIS_BITS;
  localparam int VB   = tps4d_pkg::VALUE_BITS;

  logic [tps4d_pkg::DIM_REG_BITS-1:0] dim_q [NAX];
  logic [AXB-1:0]                     perm_q [NAX];
  logic [SW-1:0]                      s_eff [NAX];
  logic [DIM_BITS-1:0]                pos_q [NAX];
  logic [DIM_BITS-1:0]                pos_d [NAX];
  logic [NAX-1:0]                     at_end;
  logic                               last_now;
  logic                               adv;
  logic                               acc;

  // stride registers
  logic [SW-1:0]        sc_q;
  logic [ADDR_BITS-1:0] nstr0_q, nstr1_q, nstr2_q;
  logic [WIDE-1:0]      nstr1_full, nstr0_full;

  // pipeline
  logic                 v1_q, v2_q, v3_q, out_valid_q;
  logic [VB-1:0]        val1_q, val2_q, val3_q, val_out_q;
  logic                 last1_q, last2_q, last3_q, last_out_q;
  logic [DIM_BITS-1:0]  dp1_q [NAX];
  logic [DIM_BITS-1:0]  pos0_2_q, pos3_2_q;
  logic [ADDR_BITS-1:0] prod1_q, prod2_q, prod0_q, part_q, dest_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int k = 0; k < NAX; k++) begin
        dim_q[k]  <= tps4d_pkg::DIM_REG_BITS'(1);
        perm_q[k] <= AXB'(k);
      end
    end else if (cfg_we_i) begin
      case (tps4d_pkg::cfg_idx_e'(cfg_index_i))
        tps4d_pkg::CFG_DIM_0:  dim_q[0]  <= cfg_data_i;
        tps4d_pkg::CFG_DIM_1:  dim_q[1]  <= cfg_data_i;
        tps4d_pkg::CFG_DIM_2:  dim_q[2]  <= cfg_data_i;
        tps4d_pkg::CFG_DIM_3:  dim_q[3]  <= cfg_data_i;
        tps4d_pkg::CFG_PERM_0: perm_q[0] <= cfg_data_i[AXB-1:0];
        tps4d_pkg::CFG_PERM_1: perm_q[1] <= cfg_data_i[AXB-1:0];
        tps4d_pkg::CFG_PERM_2: perm_q[2] <= cfg_data_i[AXB-1:0];
        tps4d_pkg::CFG_PERM_3: perm_q[3] <= cfg_data_i[AXB-1:0];
        default: ;
      endcase
    end
  end

  // zero dim reads as 1, oversized dim clamps to 2^DIM_BITS
  always_comb begin
    for (int k = 0; k < NAX; k++) begin
      if (dim_q[k] == '0) begin
        s_eff[k] = SW'(1);
      end else if (32'(dim_q[k]) > 32'(MAXD)) begin
        s_eff[k] = SW'(MAXD);
      end else begin
        s_eff[k] = SW'(dim_q[k]);
      end
      at_end[k] = 32'(pos_q[k]) >= (32'(s_eff[k]) - 32'd1);
    end
  end

  assign last_now = &at_end;

  always_comb begin
    logic carry;
    carry = 1'b1;
    for (int k = NAX - 1; k >= 0; k--) begin
      pos_d[k] = pos_q[k];
      if (carry) begin
        if (at_end[k]) begin
          pos_d[k] = '0;
        end else begin
          pos_d[k] = pos_q[k] + DIM_BITS'(1);
          carry    = 1'b0;
        end
      end
    end
  end

  assign adv        = !out_valid_q || out_ready_i;
  assign acc        = in_valid_i && adv;
  assign in_ready_o = adv;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int k = 0; k < NAX; k++) begin
        pos_q[k] <= '0;
      end
    end else if (acc) begin
      for (int k = 0; k < NAX; k++) begin
        pos_q[k] <= pos_d[k];
      end
    end
  end

  assign nstr1_full = WIDE'(s_eff[perm_q[3]]) * WIDE'(s_eff[perm_q[2]]);
  assign nstr0_full = WIDE'(nstr1_q) * WIDE'(sc_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sc_q    <= SW'(1);
      nstr2_q <= ADDR_BITS'(1);
      nstr1_q <= ADDR_BITS'(1);
      nstr0_q <= ADDR_BITS'(1);
    end else begin
      sc_q    <= s_eff[perm_q[1]];
      nstr2_q <= ADDR_BITS'(WIDE'(s_eff[perm_q[3]]));
      nstr1_q <= nstr1_full[ADDR_BITS-1:0];
      nstr0_q <= nstr0_full[ADDR_BITS-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q        <= 1'b0;
      v2_q        <= 1'b0;
      v3_q        <= 1'b0;
      out_valid_q <= 1'b0;
    end else if (adv) begin
      v1_q        <= in_valid_i;
      v2_q        <= v1_q;
      v3_q        <= v2_q;
      out_valid_q <= v3_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (acc) begin
      val1_q  <= element_value_i;
      last1_q <= last_now;
      for (int k = 0; k < NAX; k++) begin
        dp1_q[k] <= pos_q[perm_q[k]];
      end
    end
    if (adv) begin
      val2_q     <= val1_q;
      last2_q    <= last1_q;
      prod1_q    <= ADDR_BITS'(dp1_q[1]) * nstr1_q;
      prod2_q    <= ADDR_BITS'(dp1_q[2]) * nstr2_q;
      pos0_2_q   <= dp1_q[0];
      pos3_2_q   <= dp1_q[3];
      val3_q     <= val2_q;
      last3_q    <= last2_q;
      prod0_q    <= ADDR_BITS'(pos0_2_q) * nstr0_q;
      part_q     <= prod1_q + prod2_q + ADDR_BITS'(pos3_2_q);
      val_out_q  <= val3_q;
      last_out_q <= last3_q;
      dest_q     <= prod0_q + part_q;
    end
  end

  assign out_valid_o    = out_valid_q;
  assign dest_index_o   = dest_q;
  assign moved_value_o  = val_out_q;
  assign last_element_o = last_out_q;

`ifndef SYNTHESIS
  a_last_wraps: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (acc && last_now) |=> (pos_q[0] == '0 && pos_q[1] == '0 &&
                           pos_q[2] == '0 && pos_q[3] == '0))
    else $error("counters did not wrap after last element");

  a_count_moves: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (acc && !last_now) |=> ({pos_q[0], pos_q[1], pos_q[2], pos_q[3]} !=
                            $past({pos_q[0], pos_q[1], pos_q[2], pos_q[3]})))
    else $error("counters held on a non-final element");

  a_stall_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !adv |=> ($stable(v1_q) && $stable(v2_q) && $stable(v3_q) && $stable(dest_q)))
    else $error("pipeline moved during stall");

  a_no_count_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !acc |=> $stable({pos_q[0], pos_q[1], pos_q[2], pos_q[3]}))
    else $error("counters moved without an accepted transaction");
`endif

endmodule

// File: sim/testbench.sv
`timescale 1ns / 1ps

module testbench;

  localparam int DIM_BITS     = 12;
  localparam int ADDR_BITS    = 24;
  localparam int DIM_MAX      = 1 << DIM_BITS;
  localparam int PIPE_LATENCY = 3;
  localparam int DRAIN_LIMIT  = 20000;
  localparam int RANDOM_ITEMS = 1390;

  localparam logic [tps4d_pkg::NUM_AXES-1:0][tps4d_pkg::AXIS_BITS-1:0] PERM_IDENTITY =
    {2'd3, 2'd2, 2'd1, 2'd0};

  typedef struct packed {
    logic [ADDR_BITS-1:0]             dest_index;
    logic [tps4d_pkg::VALUE_BITS-1:0] moved_value;
    logic                             last_element;
  } scatter_t;

  logic                                 clk_i = 1'b0;
  logic                                 rst_ni = 1'b0;
  logic                                 cfg_we_i = 1'b0;
  logic [tps4d_pkg::CFG_INDEX_BITS-1:0] cfg_index_i = '0;
  logic [tps4d_pkg::CFG_DATA_BITS-1:0]  cfg_data_i = '0;
  logic                                 in_valid_i = 1'b0;
  logic                                 in_ready_o;
  logic [tps4d_pkg::VALUE_BITS-1:0]     element_value_i = '0;
  logic                                 out_valid_o;
  logic                                 out_ready_i = 1'b0;
  logic [ADDR_BITS-1:0]                 dest_index_o;
  logic [tps4d_pkg::VALUE_BITS-1:0]     moved_value_o;
  logic                                 last_element_o;

  tensor_permute_scatter_4d #(
    .DIM_BITS  (DIM_BITS),
    .ADDR_BITS (ADDR_BITS)
  ) dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_we_i        (cfg_we_i),
    .cfg_index_i     (cfg_index_i),
    .cfg_data_i      (cfg_data_i),
    .in_valid_i      (in_valid_i),
    .in_ready_o      (in_ready_o),
    .element_value_i (element_value_i),
    .out_valid_o     (out_valid_o),
    .out_ready_i     (out_ready_i),
    .dest_index_o    (dest_index_o),
    .moved_value_o   (moved_value_o),
    .last_element_o  (last_element_o)
  );

  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  // shadow copy of the block: registers and source coordinates
  logic [tps4d_pkg::NUM_AXES-1:0][tps4d_pkg::DIM_REG_BITS-1:0] shadow_dim  =
    {tps4d_pkg::NUM_AXES{13'd1}};
  logic [tps4d_pkg::NUM_AXES-1:0][tps4d_pkg::AXIS_BITS-1:0]    shadow_perm = PERM_IDENTITY;
  logic [tps4d_pkg::NUM_AXES-1:0][DIM_BITS-1:0]                coord       = '0;

  scatter_t expected_scatter_q[$];
  int       error_count = 0;

  int burst_left = 0;
  bit tx_gaps_on = 1'b1;

  int hold_req_seq = 0;
  int hold_req_len = 0;
  int hold_seen    = 0;
  int hold_left    = 0;
  int rx_mode      = 0;
  int rx_mode_left = 0;
  int rx_tick      = 0;

  task automatic report_mismatch(input string what, input logic [63:0] got,
                                 input logic [63:0] want);
    error_count++;
    $display("%0t ns: %s: got 0x%0h, want 0x%0h", $time, what, got, want);
  endtask

  function automatic longint unsigned eff_size(
    input logic [tps4d_pkg::DIM_REG_BITS-1:0] d);
    if (d == 0) return 1;
    if (d > DIM_MAX) return DIM_MAX;
    return d;
  endfunction

  task automatic predict_scatter(input logic [tps4d_pkg::VALUE_BITS-1:0] value);
    longint unsigned size [tps4d_pkg::NUM_AXES];
    longint unsigned stride [tps4d_pkg::NUM_AXES];
    longint unsigned sum;
    logic [tps4d_pkg::NUM_AXES-1:0] at_end;
    logic carry;
    scatter_t item;
    for (int k = 0; k < tps4d_pkg::NUM_AXES; k++) size[k] = eff_size(shadow_dim[k]);
    stride[3] = 1;
    stride[2] = size[shadow_perm[3]];
    stride[1] = stride[2] * size[shadow_perm[2]];
    stride[0] = stride[1] * size[shadow_perm[1]];
    sum = 0;
    for (int k = 0; k < tps4d_pkg::NUM_AXES; k++)
      sum += coord[shadow_perm[k]] * stride[k];
    for (int k = 0; k < tps4d_pkg::NUM_AXES; k++) at_end[k] = coord[k] >= size[k] - 1;
    item.dest_index   = sum[ADDR_BITS-1:0];
    item.moved_value  = value;
    item.last_element = &at_end;
    expected_scatter_q.push_back(item);
    carry = 1'b1;
    for (int k = tps4d_pkg::NUM_AXES - 1; k >= 0; k--) begin
      if (carry) begin
        if (at_end[k]) begin
          coord[k] = '0;
        end else begin
          coord[k] = coord[k] + 1'b1;
          carry = 1'b0;
        end
      end
    end
  endtask

  task automatic send_element(input logic [tps4d_pkg::VALUE_BITS-1:0] value);
    int gap;
    if (tx_gaps_on) begin
      if (burst_left == 0) begin
        gap = $urandom_range(0, 6);
        burst_left = $urandom_range(1, 16);
        if (gap > 0) begin
          in_valid_i <= 1'b0;
          repeat (gap) @(posedge clk_i);
        end
      end
      burst_left--;
    end
    in_valid_i      <= 1'b1;
    element_value_i <= value;
    do @(posedge clk_i); while (!in_ready_o);
    predict_scatter(value);
  endtask

  // stop offering and let every expected transaction come back
  task automatic wait_idle();
    int guard;
    guard = 0;
    in_valid_i <= 1'b0;
    burst_left = 0;
    while (expected_scatter_q.size() != 0 && guard < DRAIN_LIMIT) begin
      @(posedge clk_i);
      guard++;
    end
    repeat (PIPE_LATENCY + 2) @(posedge clk_i);
  endtask

  task automatic write_reg(input logic [tps4d_pkg::CFG_INDEX_BITS-1:0] idx,
                           input logic [tps4d_pkg::CFG_DATA_BITS-1:0] data);
    cfg_we_i    <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= data;
    @(posedge clk_i);
    if (idx <= tps4d_pkg::CFG_DIM_3) shadow_dim[idx[1:0]] = data;
    else if (idx <= tps4d_pkg::CFG_PERM_3)
      shadow_perm[idx[1:0]] = data[tps4d_pkg::AXIS_BITS-1:0];
  endtask

  task automatic apply_config(
    input logic [tps4d_pkg::NUM_AXES-1:0][tps4d_pkg::DIM_REG_BITS-1:0] dims,
    input logic [tps4d_pkg::NUM_AXES-1:0][tps4d_pkg::AXIS_BITS-1:0]    perm,
    input bit junk_write);
    logic [tps4d_pkg::CFG_DATA_BITS-tps4d_pkg::AXIS_BITS-1:0] upper;
    logic [tps4d_pkg::CFG_INDEX_BITS-1:0]                     junk_idx;
    wait_idle();
    for (int k = 0; k < tps4d_pkg::NUM_AXES; k++)
      write_reg(tps4d_pkg::CFG_INDEX_BITS'(tps4d_pkg::CFG_DIM_0 + k), dims[k]);
    for (int k = 0; k < tps4d_pkg::NUM_AXES; k++) begin
      upper = (tps4d_pkg::CFG_DATA_BITS - tps4d_pkg::AXIS_BITS)'($urandom);
      write_reg(tps4d_pkg::CFG_INDEX_BITS'(tps4d_pkg::CFG_PERM_0 + k), {upper, perm[k]});
    end
    if (junk_write) begin
      junk_idx = tps4d_pkg::CFG_INDEX_BITS'(tps4d_pkg::CFG_PERM_3 + 1 + $urandom_range(0, 7));
      write_reg(junk_idx, tps4d_pkg::CFG_DATA_BITS'($urandom));
    end
    cfg_we_i <= 1'b0;
  endtask

  task automatic test_reset_state();
    send_element('0);
    send_element('1);
  endtask

  task automatic test_transpose();
    // dims 1,1,2,3 with the two inner axes swapped; one whole tensor
    apply_config({13'd3, 13'd2, 13'd1, 13'd1}, {2'd2, 2'd3, 2'd1, 2'd0}, 1'b1);
    for (int i = 0; i < 6; i++) send_element(i[0] ? '1 : $urandom);
  endtask

  task automatic test_dim_clamp();
    // zero dim on axis 0, oversized on axes 1 and 3, full reversal
    apply_config({13'd4097, 13'd4096, 13'd8191, 13'd0}, {2'd0, 2'd1, 2'd2, 2'd3}, 1'b1);
    for (int i = 0; i < 3; i++) send_element($urandom);
  endtask

  task automatic test_repeated_axes();
    apply_config({13'd2, 13'd2, 13'd2, 13'd2}, {2'd3, 2'd3, 2'd1, 2'd1}, 1'b0);
    for (int i = 0; i < 3; i++) send_element($urandom);
  endtask

  task automatic test_mid_tensor_change();
    // advance the outer counter, then grow the tensor past the address range
    apply_config({13'd1, 13'd1, 13'd1, 13'd8}, PERM_IDENTITY, 1'b0);
    for (int i = 0; i < 3; i++) send_element($urandom);
    apply_config({13'd4095, 13'd4095, 13'd4095, 13'd4095}, PERM_IDENTITY, 1'b0);
    for (int i = 0; i < 2; i++) send_element($urandom);
    // shrink below the current coordinates
    apply_config({13'd2, 13'd2, 13'd2, 13'd2}, {2'd0, 2'd2, 2'd1, 2'd3}, 1'b0);
    for (int i = 0; i < 2; i++) send_element('1);
  endtask

  task automatic test_backpressure();
    apply_config({13'd4, 13'd3, 13'd2, 13'd2}, {2'd1, 2'd0, 2'd3, 2'd2}, 1'b0);
    tx_gaps_on = 1'b0;
    hold_req_len = 300;
    hold_req_seq++;
    for (int i = 0; i < 40; i++) send_element($urandom);
    wait_idle();
    tx_gaps_on = 1'b1;
  endtask

  task automatic test_random_phases();
    int sent;
    int n;
    int j;
    longint unsigned vol;
    logic [tps4d_pkg::NUM_AXES-1:0][tps4d_pkg::DIM_REG_BITS-1:0] dims;
    logic [tps4d_pkg::NUM_AXES-1:0][tps4d_pkg::AXIS_BITS-1:0]    perm;
    logic [tps4d_pkg::AXIS_BITS-1:0]                             swap;
    logic [tps4d_pkg::VALUE_BITS-1:0]                            value;
    sent = 0;
    while (sent < RANDOM_ITEMS) begin
      vol = 1;
      for (int k = 0; k < tps4d_pkg::NUM_AXES; k++) begin
        case ($urandom_range(0, 9))
          0:       dims[k] = '0;
          1:       dims[k] = tps4d_pkg::DIM_REG_BITS'(
                     $urandom_range(DIM_MAX + 1, (1 << tps4d_pkg::DIM_REG_BITS) - 1));
          2:       dims[k] = tps4d_pkg::DIM_REG_BITS'($urandom_range(1, DIM_MAX));
          default: dims[k] = tps4d_pkg::DIM_REG_BITS'($urandom_range(1, 5));
        endcase
        vol *= eff_size(dims[k]);
      end
      if ($urandom_range(0, 3) == 0) begin
        for (int k = 0; k < tps4d_pkg::NUM_AXES; k++)
          perm[k] = tps4d_pkg::AXIS_BITS'($urandom);
      end else begin
        perm = PERM_IDENTITY;
        for (int k = tps4d_pkg::NUM_AXES - 1; k > 0; k--) begin
          j = $urandom_range(0, k);
          swap = perm[k];
          perm[k] = perm[j];
          perm[j] = swap;
        end
      end
      apply_config(dims, perm, $urandom_range(0, 3) == 0);
      tx_gaps_on = ($urandom_range(0, 3) != 0);
      if (vol <= 48) n = int'(vol) * $urandom_range(1, 3) + $urandom_range(0, 3);
      else n = $urandom_range(4, 40);
      for (int i = 0; i < n; i++) begin
        case ($urandom_range(0, 15))
          0:       value = '0;
          1:       value = '1;
          default: value = $urandom;
        endcase
        send_element(value);
      end
      sent += n;
    end
    tx_gaps_on = 1'b1;
  endtask

  // result side: check each transaction, then pick the next ready value
  always @(posedge clk_i) begin : check_results
    scatter_t want;
    if (rst_ni) begin
      if (out_valid_o && out_ready_i) begin
        if (expected_scatter_q.size() == 0) begin
          report_mismatch("result with nothing expected", 64'(dest_index_o), 64'(0));
        end else begin
          want = expected_scatter_q.pop_front();
          if (dest_index_o !== want.dest_index)
            report_mismatch("dest_index", 64'(dest_index_o), 64'(want.dest_index));
          if (moved_value_o !== want.moved_value)
            report_mismatch("moved_value", 64'(moved_value_o), 64'(want.moved_value));
          if (last_element_o !== want.last_element)
            report_mismatch("last_element", 64'(last_element_o), 64'(want.last_element));
        end
      end
      if (hold_seen != hold_req_seq) begin
        hold_seen = hold_req_seq;
        hold_left = hold_req_len;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_ready_i <= 1'b0;
      end else begin
        if (rx_mode_left == 0) begin
          rx_mode = $urandom_range(0, 3);
          rx_mode_left = $urandom_range(20, 200);
        end
        rx_mode_left--;
        rx_tick++;
        case (rx_mode)
          0:       out_ready_i <= 1'b1;
          1:       out_ready_i <= 1'($urandom_range(0, 1));
          2:       out_ready_i <= ($urandom_range(0, 7) != 0);
          default: out_ready_i <= (rx_tick % 7) < 4;
        endcase
      end
    end
  end

  initial begin
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_reset_state();
    test_transpose();
    test_dim_clamp();
    test_repeated_axes();
    test_mid_tensor_change();
    test_backpressure();
    test_random_phases();
    wait_idle();
    if (expected_scatter_q.size() != 0)
      report_mismatch("results never delivered", 64'(expected_scatter_q.size()), 64'(0));
    if (error_count == 0) begin
      $display("** tensor_permute_scatter_4d: PASSED **");
    end else begin
      $display("** tensor_permute_scatter_4d: FAILED **");
    end
    $finish;
  end

  initial begin
    #2000000;
    $display("** tensor_permute_scatter_4d: FAILED **");
    $finish;
  end

endmodule
